### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; clk and rst_n are taken from the scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CGAEPG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CGAEPG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cgaepg_pkg.sv
// ----------------------------------------------------------------------------
// cgaepg_pkg
// Shared types, register map, bit positions and the 16-color RGB table.
// ----------------------------------------------------------------------------
package cgaepg_pkg;

    localparam int ADDR_W              = 4;
    localparam int DATA_W              = 32;
    localparam int REG_W               = 8;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int PIX_MAX   = 16;
    localparam int PIX_CNT_W = 4;
    localparam logic [PIX_CNT_W-1:0] PIX_LAST_NARROW = 4'd7;
    localparam logic [PIX_CNT_W-1:0] PIX_LAST_WIDE   = 4'd15;

    // register index = paddr[3:2]
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COLOR = 2'd1;
    localparam logic [1:0] REG_EXT   = 2'd2;

    // mode_control bits
    localparam int MC_GRAPHICS = 1;
    localparam int MC_BURST    = 2;
    localparam int MC_ENABLE   = 3;
    localparam int MC_HIRES    = 4;
    localparam int MC_BLINK    = 5;
    // color_select bits
    localparam int CS_INTENS   = 4;
    localparam int CS_PALETTE  = 5;
    // extension_control bits
    localparam int EXT_C16     = 4;
    localparam int EXT_HI4     = 5;

    typedef enum logic [2:0] {
        MODE_BLANK,
        MODE_TEXT,
        MODE_CGA4,
        MODE_MONO,
        MODE_C16,
        MODE_HI4
    } mode_t;

    typedef struct packed {
        logic [REG_W-1:0] mode_control;
        logic [REG_W-1:0] color_select;
        logic [REG_W-1:0] extension_control;
    } cfg_t;

    // one cell: color index per pixel, pixel 0 in entry 0
    typedef struct packed {
        logic [PIX_MAX-1:0][3:0] idx;
        logic                    wide;
    } cell_t;

    typedef struct packed {
        logic  valid;
        cell_t entry;
    } queue_head_t;

    function automatic logic [23:0] colour_rgb(input logic [3:0] c);
        logic [23:0] rgb;
        unique case (c)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h0000aa;
            4'd2:    rgb = 24'h00aa00;
            4'd3:    rgb = 24'h00aaaa;
            4'd4:    rgb = 24'haa0000;
            4'd5:    rgb = 24'haa00aa;
            4'd6:    rgb = 24'haa5500;
            4'd7:    rgb = 24'haaaaaa;
            4'd8:    rgb = 24'h555555;
            4'd9:    rgb = 24'h5555ff;
            4'd10:   rgb = 24'h55ff55;
            4'd11:   rgb = 24'h55ffff;
            4'd12:   rgb = 24'hff5555;
            4'd13:   rgb = 24'hff55ff;
            4'd14:   rgb = 24'hffff55;
            default: rgb = 24'hffffff;
        endcase
        return rgb;
    endfunction

endpackage

### hdl/cgaepg_front.sv
// ----------------------------------------------------------------------------
// cgaepg_front
// Decodes the display mode and turns one fetched cell into per-pixel color
// indices for the pixel queue.
// ----------------------------------------------------------------------------
module cgaepg_front (
    input  logic                cell_valid,
    output logic                cell_ready,
    input  logic [15:0]         plane0_word,
    input  logic [15:0]         plane1_word,
    input  logic [7:0]          text_attribute,
    input  logic [7:0]          glyph_row,
    input  logic                cursor_here,
    input  logic [7:0]          cursor_bits,
    input  logic                blink_phase,
    input  cgaepg_pkg::cfg_t    cfg,
    output logic                push,
    output cgaepg_pkg::cell_t   push_cell,
    input  logic                queue_ready
);

    cgaepg_pkg::mode_t mode;
    logic [7:0]        attr_eff;
    logic [7:0]        glyph_eff;

    function automatic logic [3:0] pal(input logic [1:0] i, input cgaepg_pkg::cfg_t c);
        logic [2:0] v;
        logic [3:0] r;
        if (c.mode_control[cgaepg_pkg::MC_BURST])
            v = (i == 2'd1) ? 3'd3 : (i == 2'd2) ? 3'd4 : 3'd7;
        else if (c.color_select[cgaepg_pkg::CS_PALETTE])
            v = (i == 2'd1) ? 3'd3 : (i == 2'd2) ? 3'd5 : 3'd7;
        else
            v = (i == 2'd1) ? 3'd2 : (i == 2'd2) ? 3'd4 : 3'd6;
        r = (i == 2'd0) ? c.color_select[3:0]
                        : {c.color_select[cgaepg_pkg::CS_INTENS], v};
        return r;
    endfunction

    assign cell_ready = queue_ready;
    assign push       = cell_valid;

    always_comb
    begin
        priority if (!cfg.mode_control[cgaepg_pkg::MC_ENABLE])
            mode = cgaepg_pkg::MODE_BLANK;
        else if (!cfg.mode_control[cgaepg_pkg::MC_GRAPHICS])
            mode = cgaepg_pkg::MODE_TEXT;
        else if (cfg.extension_control[cgaepg_pkg::EXT_C16])
            mode = cgaepg_pkg::MODE_C16;
        else if (cfg.extension_control[cgaepg_pkg::EXT_HI4])
            mode = cgaepg_pkg::MODE_HI4;
        else if (cfg.mode_control[cgaepg_pkg::MC_HIRES])
            mode = cgaepg_pkg::MODE_MONO;
        else
            mode = cgaepg_pkg::MODE_CGA4;
    end

    // text blink and cursor
    always_comb
    begin
        attr_eff = text_attribute;
        if (text_attribute[7] && cfg.mode_control[cgaepg_pkg::MC_BLINK])
        begin
            if (blink_phase)
                attr_eff = {1'b0, text_attribute[6:0]};
            else
                attr_eff = {1'b0, text_attribute[6:4], 1'b0, text_attribute[6:4]};
        end
        glyph_eff = glyph_row | ((cursor_here && blink_phase) ? cursor_bits : 8'h00);
    end

    always_comb
    begin
        push_cell = '0;
        unique case (mode)
            cgaepg_pkg::MODE_BLANK:
            begin
                push_cell.wide = 1'b0;
            end
            cgaepg_pkg::MODE_TEXT:
            begin
                for (int j = 0; j < 8; j++)
                    push_cell.idx[j] = glyph_eff[7-j] ? attr_eff[3:0] : attr_eff[7:4];
            end
            cgaepg_pkg::MODE_C16:
            begin
                for (int j = 0; j < 8; j++)
                    push_cell.idx[j] = {plane1_word[14-2*j], plane0_word[15-2*j],
                                        plane0_word[14-2*j], plane1_word[15-2*j]};
            end
            cgaepg_pkg::MODE_HI4:
            begin
                push_cell.wide = 1'b1;
                for (int j = 0; j < 16; j++)
                    push_cell.idx[j] = pal({plane1_word[15-j], plane0_word[15-j]}, cfg);
            end
            cgaepg_pkg::MODE_MONO:
            begin
                push_cell.wide = 1'b1;
                for (int j = 0; j < 16; j++)
                    push_cell.idx[j] = plane0_word[15-j] ? cfg.color_select[3:0] : 4'd0;
            end
            default:
            begin
                for (int j = 0; j < 8; j++)
                    push_cell.idx[j] = pal(plane0_word[15-2*j -: 2], cfg);
            end
        endcase
    end

endmodule

### hdl/cgaepg_fifo.sv
// ----------------------------------------------------------------------------
// cgaepg_fifo
// Short queue of decoded cells between the decode and serializer sides.
// ----------------------------------------------------------------------------
module cgaepg_fifo #(
    parameter int DEPTH = cgaepg_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  cgaepg_pkg::cell_t         push_cell,
    output logic                      push_ready,
    output cgaepg_pkg::queue_head_t   head,
    input  logic                      pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cgaepg_pkg::cell_t slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign do_push    = push && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cell;
    end

endmodule

### hdl/cgaepg_back.sv
// ----------------------------------------------------------------------------
// cgaepg_back
// Pixel serializer: steps through the current cell one pixel per beat,
// maps the color index to RGB and holds it in the output register.
// ----------------------------------------------------------------------------
module cgaepg_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cgaepg_pkg::queue_head_t   head,
    output logic                      pop,
    output logic                      pixel_valid,
    input  logic                      pixel_ready,
    output logic [7:0]                red,
    output logic [7:0]                green,
    output logic [7:0]                blue,
    output logic                      last_pixel
);

    cgaepg_pkg::cell_t                 cur_reg, cur_next;
    logic                              cur_valid_reg, cur_valid_next;
    logic [cgaepg_pkg::PIX_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                              out_valid_reg, out_valid_next;
    logic [23:0]                       rgb_reg, rgb_next;
    logic                              last_reg, last_next;
    logic                              adv, is_last;

    assign is_last = (cnt_reg == (cur_reg.wide ? cgaepg_pkg::PIX_LAST_WIDE
                                               : cgaepg_pkg::PIX_LAST_NARROW));
    assign adv     = cur_valid_reg && (!out_valid_reg || pixel_ready);
    assign pop     = head.valid && (!cur_valid_reg || (adv && is_last));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        cnt_next       = cnt_reg;
        if (pop)
        begin
            cur_next       = head.entry;
            cur_valid_next = 1'b1;
            cnt_next       = '0;
        end
        else if (adv)
        begin
            if (is_last)
                cur_valid_next = 1'b0;
            else
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        rgb_next       = rgb_reg;
        last_next      = last_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            rgb_next       = cgaepg_pkg::colour_rgb(cur_reg.idx[cnt_reg]);
            last_next      = is_last;
        end
        else if (pixel_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        rgb_reg  <= rgb_next;
        last_reg <= last_next;
    end

    assign pixel_valid = out_valid_reg;
    assign red         = rgb_reg[23:16];
    assign green       = rgb_reg[15:8];
    assign blue        = rgb_reg[7:0];
    assign last_pixel  = last_reg;

endmodule

### hdl/cga_extended_pixel_generator_top.sv
// ----------------------------------------------------------------------------
// cga_extended_pixel_generator_top
// Character cell to RGB pixel stream with APB mode/color registers.
//
//   channel  | signals                                   | beat
//   ---------+-------------------------------------------+------------------
//   cell     | cell_valid/cell_ready + 7 field ports     | one cell
//   pixel    | pixel_valid/pixel_ready, red/green/blue,  | one pixel
//            | last_pixel                                |
//   apb      | psel/penable/pwrite/paddr/pwdata/prdata   | one register
//
// One pixel per clock leaves the serializer while pixel_ready is high; 8
// pixels per cell (16 in mono 640 and 4-color 640). The first pixel passes a
// queue slot, cur_reg and rgb_reg. Cells are decoded on acceptance and queued
// QUEUE_DEPTH deep, so cells are taken during a pixel stall until the queue
// is full. Reset clears control and the three registers; no clearing pass.
// ----------------------------------------------------------------------------
module cga_extended_pixel_generator_top #(
    parameter int QUEUE_DEPTH = cgaepg_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cell_valid,
    output logic                            cell_ready,
    input  logic [15:0]                     plane0_word,
    input  logic [15:0]                     plane1_word,
    input  logic [7:0]                      text_attribute,
    input  logic [7:0]                      glyph_row,
    input  logic                            cursor_here,
    input  logic [7:0]                      cursor_bits,
    input  logic                            blink_phase,
    output logic                            pixel_valid,
    input  logic                            pixel_ready,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic                            last_pixel,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cgaepg_pkg::ADDR_W-1:0]   paddr,
    input  logic [cgaepg_pkg::DATA_W-1:0]   pwdata,
    output logic [cgaepg_pkg::DATA_W-1:0]   prdata,
    output logic                            pready
);

    cgaepg_pkg::cfg_t          cfg_reg, cfg_next;
    cgaepg_pkg::cell_t         push_cell;
    cgaepg_pkg::queue_head_t   head;
    logic                      push, queue_ready, pop, wr_en;
    logic [1:0]                reg_idx;
    logic [cgaepg_pkg::REG_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                cgaepg_pkg::REG_MODE:  cfg_next.mode_control      = pwdata[7:0];
                cgaepg_pkg::REG_COLOR: cfg_next.color_select      = pwdata[7:0];
                cgaepg_pkg::REG_EXT:   cfg_next.extension_control = pwdata[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            cgaepg_pkg::REG_MODE:  rd_val = cfg_reg.mode_control;
            cgaepg_pkg::REG_COLOR: rd_val = cfg_reg.color_select;
            cgaepg_pkg::REG_EXT:   rd_val = cfg_reg.extension_control;
            default:               rd_val = '0;
        endcase
    end

    assign prdata = {{(cgaepg_pkg::DATA_W - cgaepg_pkg::REG_W){1'b0}}, rd_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    cgaepg_front u_front (
        .cell_valid     (cell_valid),
        .cell_ready     (cell_ready),
        .plane0_word    (plane0_word),
        .plane1_word    (plane1_word),
        .text_attribute (text_attribute),
        .glyph_row      (glyph_row),
        .cursor_here    (cursor_here),
        .cursor_bits    (cursor_bits),
        .blink_phase    (blink_phase),
        .cfg            (cfg_reg),
        .push           (push),
        .push_cell      (push_cell),
        .queue_ready    (queue_ready)
    );

    cgaepg_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cell  (push_cell),
        .push_ready (queue_ready),
        .head       (head),
        .pop        (pop)
    );

    cgaepg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_pixel  (last_pixel)
    );

endmodule

### hdl/cgaepg_checker.sv
// ----------------------------------------------------------------------------
// cgaepg_checker
// Port-level checks on the pixel stream: cell length, blank output, stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cgaepg_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    input  logic                            pixel_ready,
    input  logic [7:0]                      red,
    input  logic [7:0]                      green,
    input  logic [7:0]                      blue,
    input  logic                            last_pixel,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cgaepg_pkg::ADDR_W-1:0]   paddr,
    input  logic [cgaepg_pkg::DATA_W-1:0]   pwdata,
    input  logic                            pready
);

    logic [cgaepg_pkg::PIX_CNT_W-1:0] cnt_reg, cnt_next;
    logic                             enable_reg, enable_next;
    logic                             pix_acc, pix_end, pix_stall;
    logic                             at_narrow_end, last_pos_ok, blank_ok;
    logic [24:0]                      beat_data;

    assign pix_acc       = pixel_valid && pixel_ready;
    assign pix_end       = pix_acc && last_pixel;
    assign pix_stall     = pixel_valid && !pixel_ready;
    assign beat_data     = {red, green, blue, last_pixel};
    assign at_narrow_end = (cnt_reg == cgaepg_pkg::PIX_LAST_NARROW);
    assign last_pos_ok   = at_narrow_end || (cnt_reg == cgaepg_pkg::PIX_LAST_WIDE);
    assign blank_ok      = (beat_data[24:1] == 24'h000000) && (at_narrow_end == last_pixel);

    always_comb
    begin
        cnt_next    = cnt_reg;
        enable_next = enable_reg;
        if (pix_acc)
            cnt_next = last_pixel ? '0 : cnt_reg + 1'b1;
        if (psel && penable && pwrite && pready && (paddr[3:2] == cgaepg_pkg::REG_MODE))
            enable_next = pwdata[cgaepg_pkg::MC_ENABLE];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            enable_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            enable_reg <= enable_next;
        end
    end

    `CGAEPG_ASSERT_IMP(a_last_position, pix_end, last_pos_ok, "cell ends at wrong count")
    `CGAEPG_ASSERT_IMP(a_cell_max_len, pix_acc && (cnt_reg == 4'd15), last_pixel, "cell too long")
    `CGAEPG_ASSERT_IMP(a_blank_black, pix_acc && !enable_reg, blank_ok, "blank cell not black")
    `CGAEPG_ASSERT_NXT(a_pixel_hold, pix_stall, pixel_valid && $stable(beat_data), "stall changed")

endmodule

bind cga_extended_pixel_generator_top cgaepg_checker u_checker (.*);

### tb/sv/cga_extended_pixel_generator_top_test.sv
// ----------------------------------------------------------------------------
// cga_extended_pixel_generator_top_test
// Cell-to-pixel checker for the extended CGA pixel generator.
//
// Cells are driven on a valid/ready channel from a queue of pending beats.
// Each accepted cell is expanded into its expected pixels using the current
// register settings. Every pixel beat is compared against the oldest one.
// Registers are written and read back over APB only while the block is idle.
// A directed pass covers each display mode and the blink and cursor cases.
// Random cells then run under random register settings, with three
// handshake idling profiles.
// ----------------------------------------------------------------------------
module cga_extended_pixel_generator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] plane0;
        logic [15:0] plane1;
        logic [7:0]  attribute;
        logic [7:0]  glyph;
        logic        cursor_here;
        logic [7:0]  cursor_bits;
        logic        blink;
    } cell_fields_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_rgb_t;

    localparam logic [23:0] RGB_TABLE [0:15] = '{
        24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
        24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
        24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
        24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
    };

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cell_valid = 1'b0;
    logic                              cell_ready;
    cell_fields_t                      cell_out = '0;
    logic                              pixel_valid;
    logic                              pixel_ready = 1'b0;
    logic [7:0]                        red;
    logic [7:0]                        green;
    logic [7:0]                        blue;
    logic                              last_pixel;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [cgaepg_pkg::ADDR_W-1:0]     paddr = '0;
    logic [cgaepg_pkg::DATA_W-1:0]     pwdata = '0;
    logic [cgaepg_pkg::DATA_W-1:0]     prdata;
    logic                              pready;

    cell_fields_t        pending_cells[$];
    pixel_rgb_t          pixels_expected[$];

    logic [7:0]          mode_reg = 8'h00;
    logic [7:0]          color_reg = 8'h00;
    logic [7:0]          ext_reg = 8'h00;

    int                  send_idle_pct = 33;
    int                  recv_idle_pct = 57;
    int                  errors = 0;
    int                  reports = 0;
    int                  cells_sent = 0;
    int                  pixels_checked = 0;
    int                  settings_used = 0;

    cga_extended_pixel_generator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cell_valid     (cell_valid),
        .cell_ready     (cell_ready),
        .plane0_word    (cell_out.plane0),
        .plane1_word    (cell_out.plane1),
        .text_attribute (cell_out.attribute),
        .glyph_row      (cell_out.glyph),
        .cursor_here    (cell_out.cursor_here),
        .cursor_bits    (cell_out.cursor_bits),
        .blink_phase    (cell_out.blink),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .last_pixel     (last_pixel),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic cgaepg_pkg::mode_t cell_mode();
        if (!mode_reg[cgaepg_pkg::MC_ENABLE])
            return cgaepg_pkg::MODE_BLANK;
        if (!mode_reg[cgaepg_pkg::MC_GRAPHICS])
            return cgaepg_pkg::MODE_TEXT;
        if (ext_reg[cgaepg_pkg::EXT_C16])
            return cgaepg_pkg::MODE_C16;
        if (ext_reg[cgaepg_pkg::EXT_HI4])
            return cgaepg_pkg::MODE_HI4;
        if (mode_reg[cgaepg_pkg::MC_HIRES])
            return cgaepg_pkg::MODE_MONO;
        return cgaepg_pkg::MODE_CGA4;
    endfunction

    function automatic logic [3:0] palette_colour(input logic [1:0] i);
        logic [3:0] v;
        if (i == 2'd0)
            return color_reg[3:0];
        if (mode_reg[cgaepg_pkg::MC_BURST])
            v = (i == 2'd1) ? 4'd3 : (i == 2'd2) ? 4'd4 : 4'd7;
        else if (color_reg[cgaepg_pkg::CS_PALETTE])
            v = (i == 2'd1) ? 4'd3 : (i == 2'd2) ? 4'd5 : 4'd7;
        else
            v = (i == 2'd1) ? 4'd2 : (i == 2'd2) ? 4'd4 : 4'd6;
        if (color_reg[cgaepg_pkg::CS_INTENS])
            v = v | 4'd8;
        return v;
    endfunction

    function automatic void expect_cell_pixels(input cell_fields_t c);
        cgaepg_pkg::mode_t m;
        int                n;
        int                s;
        logic [7:0]        attr;
        logic [7:0]        glyph;
        logic [3:0]        col;
        pixel_rgb_t        px;
        m = cell_mode();
        n = (m == cgaepg_pkg::MODE_MONO || m == cgaepg_pkg::MODE_HI4) ? 16 : 8;
        attr = c.attribute;
        glyph = c.glyph;
        // blink attribute: fg hidden in phase zero, bit7 never reaches bg
        if (attr[7] && mode_reg[cgaepg_pkg::MC_BLINK])
        begin
            if (!c.blink)
                attr = {1'b0, attr[6:4], 1'b0, attr[6:4]};
            else
                attr[7] = 1'b0;
        end
        if (c.cursor_here && c.blink)
            glyph = glyph | c.cursor_bits;
        for (int j = 0; j < n; j++)
        begin
            case (m)
                cgaepg_pkg::MODE_TEXT:
                    col = glyph[7-j] ? attr[3:0] : attr[7:4];
                cgaepg_pkg::MODE_CGA4:
                begin
                    s = 14 - 2 * j;
                    col = palette_colour(c.plane0[s +: 2]);
                end
                cgaepg_pkg::MODE_MONO:
                    col = c.plane0[15-j] ? color_reg[3:0] : 4'd0;
                cgaepg_pkg::MODE_C16:
                begin
                    s = 14 - 2 * j;
                    col = {c.plane1[s], c.plane0[s+1], c.plane0[s], c.plane1[s+1]};
                end
                cgaepg_pkg::MODE_HI4:
                    col = palette_colour({c.plane1[15-j], c.plane0[15-j]});
                default:
                    col = 4'd0;
            endcase
            {px.red, px.green, px.blue} = RGB_TABLE[col];
            px.last = (j == n - 1);
            pixels_expected.push_back(px);
        end
    endfunction

    function automatic logic [15:0] rand_field(input int unsigned width);
        logic [15:0] mask;
        mask = 16'((32'd1 << width) - 32'd1);
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return mask;
            default: return 16'($urandom) & mask;
        endcase
    endfunction

    // cell driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cell_valid && cell_ready)
            begin
                expect_cell_pixels(cell_out);
                cells_sent++;
            end
            if (!cell_valid || cell_ready)
            begin
                if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cell_out <= pending_cells.pop_front();
                    cell_valid <= 1'b1;
                end
                else
                begin
                    cell_valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
            begin
                if (pixels_expected.size() == 0)
                begin
                    errors++;
                    if (reports++ < 100)
                        $display("%0t: unexpected pixel beat rgb=%02h%02h%02h last=%0d",
                                 $time, red, green, blue, last_pixel);
                end
                else
                begin
                    pixel_rgb_t px;
                    px = pixels_expected.pop_front();
                    pixels_checked++;
                    if (red !== px.red || green !== px.green || blue !== px.blue ||
                        last_pixel !== px.last)
                    begin
                        errors++;
                        if (reports++ < 100)
                            $display("%0t: expected %h%h%h/%0d, actual %h%h%h/%0d",
                                     $time, px.red, px.green, px.blue, px.last,
                                     red, green, blue, last_pixel);
                    end
                end
            end
            pixel_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic apb_xfer(input logic wr, input logic [1:0] idx,
                            input logic [cgaepg_pkg::DATA_W-1:0] data,
                            output logic [cgaepg_pkg::DATA_W-1:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= cgaepg_pkg::ADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [7:0] value);
        logic [cgaepg_pkg::DATA_W-1:0] rd;
        apb_xfer(1'b1, idx, cgaepg_pkg::DATA_W'(value), rd);
        case (idx)
            cgaepg_pkg::REG_MODE:  mode_reg = value;
            cgaepg_pkg::REG_COLOR: color_reg = value;
            default:               ext_reg = value;
        endcase
        apb_xfer(1'b0, idx, '0, rd);
        if (rd[cgaepg_pkg::REG_W-1:0] !== value)
        begin
            errors++;
            if (reports++ < 100)
                $display("%0t: register %0d readback: expected %02h, actual %02h",
                         $time, idx, value, rd[cgaepg_pkg::REG_W-1:0]);
        end
    endtask

    task automatic wait_idle();
        while (pending_cells.size() != 0 || cell_valid || pixels_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] mc, input logic [7:0] cs,
                             input logic [7:0] ext);
        wait_idle();
        set_reg(cgaepg_pkg::REG_MODE, mc);
        set_reg(cgaepg_pkg::REG_COLOR, cs);
        set_reg(cgaepg_pkg::REG_EXT, ext);
        settings_used++;
    endtask

    task automatic queue_cell(input logic [15:0] p0, input logic [15:0] p1,
                              input logic [7:0] attr, input logic [7:0] glyph,
                              input logic here, input logic [7:0] cbits,
                              input logic blink);
        cell_fields_t c;
        c.plane0 = p0;
        c.plane1 = p1;
        c.attribute = attr;
        c.glyph = glyph;
        c.cursor_here = here;
        c.cursor_bits = cbits;
        c.blink = blink;
        pending_cells.push_back(c);
    endtask

    initial
    begin : stimulus
        logic [7:0] mc;
        logic [7:0] cs;
        logic [7:0] ext;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset: blank
        queue_cell(16'hffff, 16'hffff, 8'hff, 8'hff, 1'b1, 8'hff, 1'b1);

        // text, no blink attribute
        configure(8'h08, 8'h00, 8'h00);
        queue_cell(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
        queue_cell(16'hffff, 16'hffff, 8'h1e, 8'ha5, 1'b0, 8'hff, 1'b1);
        queue_cell(16'h0000, 16'h0000, 8'h4f, 8'h81, 1'b1, 8'h3c, 1'b1);
        queue_cell(16'h0000, 16'h0000, 8'h4f, 8'h81, 1'b1, 8'h3c, 1'b0);
        queue_cell(16'h0000, 16'h0000, 8'hce, 8'h0f, 1'b0, 8'h00, 1'b0);

        // text with blink attribute
        configure(8'h28, 8'h00, 8'h00);
        queue_cell(16'h0000, 16'h0000, 8'hc9, 8'hf0, 1'b0, 8'h00, 1'b0);
        queue_cell(16'h0000, 16'h0000, 8'hc9, 8'hf0, 1'b0, 8'h00, 1'b1);
        queue_cell(16'hffff, 16'h0000, 8'hff, 8'h55, 1'b1, 8'haa, 1'b1);

        // 4-color 320, each palette flavor
        configure(8'h0a, 8'h00, 8'h00);
        queue_cell(16'h1b1b, 16'hffff, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
        queue_cell(16'hffff, 16'h0000, 8'hff, 8'hff, 1'b1, 8'hff, 1'b1);
        configure(8'h0e, 8'h1f, 8'h00);
        queue_cell(16'he4e4, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
        configure(8'h0a, 8'h3a, 8'h00);
        queue_cell(16'h1be4, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);

        // mono 640
        configure(8'h1a, 8'h0c, 8'h00);
        queue_cell(16'ha5f0, 16'hffff, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
        queue_cell(16'hffff, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);

        // 16-color 320; with all bits set 16-color wins over 4-color hires
        configure(8'h0a, 8'h00, 8'h10);
        queue_cell(16'hf0a5, 16'h0f5a, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
        queue_cell(16'hffff, 16'hffff, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
        configure(8'hff, 8'hff, 8'hff);
        queue_cell(16'h1234, 16'hfedc, 8'hff, 8'hff, 1'b1, 8'hff, 1'b1);

        // 4-color 640; takes precedence over hires
        configure(8'h0a, 8'h25, 8'h20);
        queue_cell(16'h5555, 16'h3333, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
        configure(8'h1e, 8'h10, 8'h20);
        queue_cell(16'h00ff, 16'hf0f0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);

        // enable clear with everything else set, then all zero
        configure(8'hf7, 8'hff, 8'hff);
        queue_cell(16'hffff, 16'hffff, 8'hff, 8'hff, 1'b1, 8'hff, 1'b1);
        configure(8'h00, 8'h00, 8'h00);
        queue_cell(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);

        for (int blk = 0; blk < 12; blk++)
        begin
            mc = 8'($urandom);
            cs = 8'($urandom);
            ext = 8'($urandom);
            case ($urandom_range(5))
                0: mc[cgaepg_pkg::MC_ENABLE] = 1'b0;
                1:
                begin
                    mc[cgaepg_pkg::MC_ENABLE] = 1'b1;
                    mc[cgaepg_pkg::MC_GRAPHICS] = 1'b0;
                end
                2:
                begin
                    mc[cgaepg_pkg::MC_ENABLE] = 1'b1;
                    mc[cgaepg_pkg::MC_GRAPHICS] = 1'b1;
                    mc[cgaepg_pkg::MC_HIRES] = 1'b0;
                    ext[cgaepg_pkg::EXT_C16] = 1'b0;
                    ext[cgaepg_pkg::EXT_HI4] = 1'b0;
                end
                3:
                begin
                    mc[cgaepg_pkg::MC_ENABLE] = 1'b1;
                    mc[cgaepg_pkg::MC_GRAPHICS] = 1'b1;
                    mc[cgaepg_pkg::MC_HIRES] = 1'b1;
                    ext[cgaepg_pkg::EXT_C16] = 1'b0;
                    ext[cgaepg_pkg::EXT_HI4] = 1'b0;
                end
                4:
                begin
                    mc[cgaepg_pkg::MC_ENABLE] = 1'b1;
                    mc[cgaepg_pkg::MC_GRAPHICS] = 1'b1;
                    ext[cgaepg_pkg::EXT_C16] = 1'b1;
                end
                default:
                begin
                    mc[cgaepg_pkg::MC_ENABLE] = 1'b1;
                    mc[cgaepg_pkg::MC_GRAPHICS] = 1'b1;
                    ext[cgaepg_pkg::EXT_C16] = 1'b0;
                    ext[cgaepg_pkg::EXT_HI4] = 1'b1;
                end
            endcase
            configure(mc, cs, ext);
            send_idle_pct = (blk < 4) ? 33 : (blk < 8) ? 57 : 0;
            recv_idle_pct = (blk < 4) ? 57 : (blk < 8) ? 33 : 0;
            repeat (29)
                queue_cell(rand_field(16), rand_field(16), 8'(rand_field(8)),
                           8'(rand_field(8)), 1'($urandom), 8'(rand_field(8)),
                           1'($urandom));
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (pixels_expected.size() != 0)
            errors++;
        $display("Checked %0d cells, %0d pixel beats, %0d register settings",
                 cells_sent, pixels_checked, settings_used);
        $display("Modes: blank, text with blink and cursor, 4-color 320/640, mono, 16-color");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d pixel beats still expected", pixels_expected.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/cgaepg_pkg.sv
hdl/cgaepg_front.sv
hdl/cgaepg_fifo.sv
hdl/cgaepg_back.sv
hdl/cga_extended_pixel_generator_top.sv
hdl/cgaepg_checker.sv
tb/sv/cga_extended_pixel_generator_top_test.sv
